### src/keypad_debounce_long_press_unit_assert.svh
// assertion macros for the keypad debounce and long-press unit
// used by the checker; needs nothing else
`ifndef KEYPAD_DEBOUNCE_LONG_PRESS_UNIT_ASSERT_SVH
`define KEYPAD_DEBOUNCE_LONG_PRESS_UNIT_ASSERT_SVH

// clocked assertion, masked while reset is active
`define KDLP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds through reset
`define KDLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/kdlp_pkg.sv
// shared types, constants and key table for the keypad debounce unit
// no dependencies
package kdlp_pkg;

  localparam int KEY_ROWS   = 4;
  localparam int KEY_COLS   = 4;
  localparam int KEYS_W     = 16;
  localparam int KEY_IDX_W  = 4;
  localparam int CODE_W     = 7;
  localparam int STABLE_W   = 8;
  localparam int HOLD_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [STABLE_W-1:0] STABLE_MAX   = '1;
  localparam logic [HOLD_W-1:0]   HOLD_MAX     = '1;
  localparam logic [STABLE_W-1:0] STABLE_RESET = 8'd3;
  localparam logic [HOLD_W-1:0]   LONG_RESET   = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 2'd0,
    CFG_STABLE    = 2'd1,
    CFG_LONG      = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PRESS     = 3'd1,
    EV_START     = 3'd2,
    EV_LONG      = 3'd3,
    EV_SHORT_REL = 3'd4,
    EV_LONG_REL  = 3'd5
  } event_e;

  typedef struct packed {
    logic                mode;
    logic [STABLE_W-1:0] stable_threshold;
    logic [HOLD_W-1:0]   long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic                 hit;
    logic [KEY_IDX_W-1:0] idx;
  } key_t;

  typedef struct packed {
    event_e              ev;
    logic [CODE_W-1:0]   code;
    logic [HOLD_W-1:0]   dur;
  } result_t;

  // keys that lie inside the scanned rows and columns
  function automatic logic [KEYS_W-1:0] scan_mask();
    logic [KEYS_W-1:0] m;
    m = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (r < KEY_ROWS && c < KEY_COLS) begin
          m[r*4+c] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  function automatic logic [CODE_W-1:0] key_ascii(input logic [KEY_IDX_W-1:0] idx);
    logic [CODE_W-1:0] a;
    unique case (idx)
      4'd0:    a = 7'h31;
      4'd1:    a = 7'h32;
      4'd2:    a = 7'h33;
      4'd3:    a = 7'h41;
      4'd4:    a = 7'h34;
      4'd5:    a = 7'h35;
      4'd6:    a = 7'h36;
      4'd7:    a = 7'h42;
      4'd8:    a = 7'h37;
      4'd9:    a = 7'h38;
      4'd10:   a = 7'h39;
      4'd11:   a = 7'h43;
      4'd12:   a = 7'h2A;
      4'd13:   a = 7'h30;
      4'd14:   a = 7'h23;
      default: a = 7'h44;
    endcase
    return a;
  endfunction

endpackage

### src/kdlp_if.sv
// valid/ready channel interfaces for scan snapshots and key events
// depends on kdlp_pkg
interface kdlp_in_if import kdlp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEYS_W-1:0] pressed_keys;

  modport source (output valid, output pressed_keys, input ready);
  modport sink   (input valid, input pressed_keys, output ready);
endinterface

interface kdlp_out_if import kdlp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        event_res;
  logic [CODE_W-1:0] key_code;
  logic [HOLD_W-1:0] hold_ticks;

  modport source (output valid, output event_res, output key_code, output hold_ticks,
                  input ready);
  modport sink   (input valid, input event_res, input key_code, input hold_ticks,
                  output ready);
endinterface

### src/kdlp_key_enc.sv
// first closed key in row-major order within the scanned area
// depends on kdlp_pkg
module kdlp_key_enc import kdlp_pkg::*; (
  input  logic [KEYS_W-1:0] keys_i,
  output key_t              key_o
);

  localparam logic [KEYS_W-1:0] Mask = scan_mask();

  logic [KEYS_W-1:0] live;

  assign live = keys_i & Mask;

  // walk downward so the lowest set bit wins
  always_comb begin
    key_o = '0;
    for (int i = KEYS_W - 1; i >= 0; i--) begin
      if (live[i]) begin
        key_o.hit = 1'b1;
        key_o.idx = KEY_IDX_W'(i);
      end
    end
  end

endmodule

### src/kdlp_tracker.sv
// debounce counter and hold-time tracker, one update per transaction
// depends on kdlp_pkg
module kdlp_tracker import kdlp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  key_t    key_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic                 trk_vld_q, trk_vld_d;
  logic [KEY_IDX_W-1:0] trk_key_q, trk_key_d;
  logic                 latched_q, latched_d;
  logic [STABLE_W-1:0]  stable_q, stable_d;
  logic [HOLD_W-1:0]    hold_q, hold_d;
  logic [STABLE_W-1:0]  stable_inc;
  logic [HOLD_W-1:0]    hold_inc;
  logic                 same_key;

  assign same_key   = trk_vld_q && (trk_key_q == key_i.idx);
  assign stable_inc = (stable_q != STABLE_MAX) ? stable_q + 1'b1 : stable_q;
  assign hold_inc   = hold_q + 1'b1;

  always_comb begin
    trk_vld_d = trk_vld_q;
    trk_key_d = trk_key_q;
    latched_d = latched_q;
    stable_d  = stable_q;
    hold_d    = hold_q;
    res_o     = '{ev: EV_NONE, code: '0, dur: '0};
    if (!cfg_i.mode) begin
      if (key_i.hit) begin
        if (same_key) begin
          stable_d = stable_inc;
          if (stable_inc >= cfg_i.stable_threshold && !latched_q) begin
            latched_d  = 1'b1;
            hold_d     = '0;
            res_o.ev   = EV_PRESS;
            res_o.code = key_ascii(trk_key_q);
          end
        end else begin
          trk_vld_d = 1'b1;
          trk_key_d = key_i.idx;
          stable_d  = STABLE_W'(1);
        end
      end else begin
        if (stable_q != '0) begin
          stable_d = stable_q - 1'b1;
        end
        if (stable_d == '0) begin
          latched_d = 1'b0;
          trk_vld_d = 1'b0;
          trk_key_d = '0;
        end
      end
    end else begin
      priority if (key_i.hit && !trk_vld_q) begin
        trk_vld_d  = 1'b1;
        trk_key_d  = key_i.idx;
        hold_d     = '0;
        res_o.ev   = EV_START;
        res_o.code = key_ascii(key_i.idx);
      end else if (key_i.hit && same_key) begin
        if (hold_q != HOLD_MAX) begin
          hold_d = hold_inc;
          if (hold_inc == cfg_i.long_press_ticks) begin
            res_o.ev   = EV_LONG;
            res_o.code = key_ascii(trk_key_q);
          end
        end
      end else if (!key_i.hit && trk_vld_q) begin
        res_o.dur  = hold_q;
        res_o.ev   = (hold_q < cfg_i.long_press_ticks) ? EV_SHORT_REL : EV_LONG_REL;
        res_o.code = key_ascii(trk_key_q);
        trk_vld_d  = 1'b0;
        trk_key_d  = '0;
      end else begin
        // different key while one is held, or no key and none tracked: no change
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_vld_q <= 1'b0;
      trk_key_q <= '0;
      latched_q <= 1'b0;
      stable_q  <= '0;
      hold_q    <= '0;
    end else if (step_i) begin
      trk_vld_q <= trk_vld_d;
      trk_key_q <= trk_key_d;
      latched_q <= latched_d;
      stable_q  <= stable_d;
      hold_q    <= hold_d;
    end
  end

endmodule

### src/keypad_debounce_long_press_unit.sv
// Keypad debouncer and long-press classifier.
// in_i carries one scan snapshot per transaction (bit row*4+col set for a
// closed key); out_o returns exactly one event per snapshot, in order:
// event_res, key_code (ASCII, 0 with no event) and hold_ticks on releases.
// Configuration (mode, stable_threshold, long_press_ticks) is written through
// cfg_we_i / cfg_index_i / cfg_data_i, one register per cycle, while idle.
// A snapshot accepted on in_i is registered in the input register, then its
// event is registered in the result register for out_o (two register stages).
// Throughput: one snapshot per cycle unless out_o stalls; one step of
// counter logic between the input and result registers updates tracker state.
// If the receiver stalls, the result register holds its event and the input
// register keeps one more snapshot; in_i.ready drops only once both are full.
// Reset clears the tracked key, latch and both counters, empties both
// registers and restores mode 0, threshold 3 and long press 100 ticks.
// depends on kdlp_pkg, kdlp_if, kdlp_key_enc, kdlp_tracker
module keypad_debounce_long_press_unit import kdlp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kdlp_in_if.sink               in_i,
  kdlp_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  logic              s1_vld_q;
  logic [KEYS_W-1:0] s1_keys_q;
  logic              out_vld_q;
  result_t           out_q;
  logic              adv;
  key_t              key;
  result_t           res;

  assign adv        = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: 1'b0, stable_threshold: STABLE_RESET, long_press_ticks: LONG_RESET};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:   cfg_q.mode             <= cfg_data_i[0];
        CFG_STABLE: cfg_q.stable_threshold <= cfg_data_i[STABLE_W-1:0];
        CFG_LONG:   cfg_q.long_press_ticks <= cfg_data_i[HOLD_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        s1_vld_q <= 1'b1;
      end else if (adv) begin
        s1_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_keys_q <= in_i.pressed_keys;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  kdlp_key_enc u_enc (
    .keys_i (s1_keys_q),
    .key_o  (key)
  );

  kdlp_tracker u_trk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .key_i  (key),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_o.valid      = out_vld_q;
  assign out_o.event_res  = out_q.ev;
  assign out_o.key_code   = out_q.code;
  assign out_o.hold_ticks = out_q.dur;

endmodule

### src/kdlp_checker.sv
// port-level checks on the event channel of the keypad unit, with its bind
// depends on kdlp_pkg and keypad_debounce_long_press_unit_assert.svh
`include "keypad_debounce_long_press_unit_assert.svh"

module kdlp_checker import kdlp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [2:0]        event_res_i,
  input logic [CODE_W-1:0] key_code_i,
  input logic [HOLD_W-1:0] hold_ticks_i
);

  logic is_rel;

  assign is_rel = (event_res_i == EV_SHORT_REL) || (event_res_i == EV_LONG_REL);

  // stalled transaction keeps its payload
  `KDLP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_res_i) && $stable(key_code_i) && $stable(hold_ticks_i), "event changed under stall")

  `KDLP_ASSERT(a_code_none, clk_i, rst_ni, out_valid_i |-> ((event_res_i == EV_NONE) == (key_code_i == '0)), "key code does not match event")

  `KDLP_ASSERT(a_dur_rel, clk_i, rst_ni, out_valid_i && !is_rel |-> hold_ticks_i == '0, "hold ticks on a non-release event")

  // nothing is presented in the cycle after reset releases
  `KDLP_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> !out_valid_i, "event valid right after reset")

  // an output valid with no prior input transaction is impossible
  `KDLP_ASSERT(a_no_invent, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2) || $past(in_valid_i && in_ready_i, 1) || !$past(in_ready_i, 1), "event without snapshot")

endmodule

bind keypad_debounce_long_press_unit kdlp_checker u_kdlp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .event_res_i  (out_o.event_res),
  .key_code_i   (out_o.key_code),
  .hold_ticks_i (out_o.hold_ticks)
);

### verif/tb.sv
// testbench for keypad_debounce_long_press_unit: scan snapshots in, key events out
// a queue-fed driver, a checking monitor and an in-bench tracker model
// depends on kdlp_pkg, kdlp_if and the rtl of the unit
module tb;
  import kdlp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDLE_PCT    = 21;
  localparam int HOLD_OFF    = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  kdlp_in_if  in_if ();
  kdlp_out_if out_if ();

  logic                  drv_valid = 1'b0;
  logic [KEYS_W-1:0]     drv_keys  = '0;
  logic                  rdy       = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  assign in_if.valid        = drv_valid;
  assign in_if.pressed_keys = drv_keys;
  assign out_if.ready       = rdy;

  keypad_debounce_long_press_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // tracker model state and its copy of the registers
  logic                mode_q  = 1'b0;
  logic [STABLE_W-1:0] thr_q   = 8'd3;
  logic [HOLD_W-1:0]   long_q  = 16'd100;
  logic                trk_valid  = 1'b0;
  logic [3:0]          trk_key    = '0;
  logic                latched    = 1'b0;
  logic [STABLE_W-1:0] stable_cnt = '0;
  logic [HOLD_W-1:0]   hold_cnt   = '0;

  logic [KEYS_W-1:0] scan_q[$];
  result_t           pending_events[$];
  result_t           want;

  int  err_cnt       = 0;
  int  cycle_cnt     = 0;
  int  stall_left    = 0;
  bit  no_idle       = 1'b0;
  bit  hold_off_req  = 1'b0;
  bit  hold_off_done = 1'b0;

  // telephone-style 4x4 layout
  function automatic logic [CODE_W-1:0] key_char(input logic [3:0] idx);
    logic [CODE_W-1:0] c;
    case (idx)
      4'd0:  c = 7'h31;  4'd1:  c = 7'h32;  4'd2:  c = 7'h33;  4'd3:  c = 7'h41;
      4'd4:  c = 7'h34;  4'd5:  c = 7'h35;  4'd6:  c = 7'h36;  4'd7:  c = 7'h42;
      4'd8:  c = 7'h37;  4'd9:  c = 7'h38;  4'd10: c = 7'h39;  4'd11: c = 7'h43;
      4'd12: c = 7'h2A;  4'd13: c = 7'h30;  4'd14: c = 7'h23;  default: c = 7'h44;
    endcase
    return c;
  endfunction

  // one scan tick through the tracker; queues the event it causes
  function automatic void track_scan(input logic [KEYS_W-1:0] snap);
    result_t    r;
    logic       hit;
    logic [3:0] k;
    hit = 1'b0;
    k = '0;
    // scan backwards so the first closed key in row-major order wins
    for (int i = 15; i >= 0; i--) begin
      if ((i / 4) < KEY_ROWS && (i % 4) < KEY_COLS && snap[i]) begin
        hit = 1'b1;
        k = 4'(i);
      end
    end
    r.ev = EV_NONE;
    r.code = '0;
    r.dur = '0;
    if (!mode_q) begin
      if (hit) begin
        if (trk_valid && trk_key == k) begin
          if (stable_cnt != 8'hFF) stable_cnt = stable_cnt + 8'd1;
          if (stable_cnt >= thr_q && !latched) begin
            latched = 1'b1;
            hold_cnt = '0;
            r.ev = EV_PRESS;
            r.code = key_char(trk_key);
          end
        end else begin
          // new or changed key restarts the count, latch stays
          trk_valid = 1'b1;
          trk_key = k;
          stable_cnt = 8'd1;
        end
      end else begin
        if (stable_cnt != 8'd0) stable_cnt = stable_cnt - 8'd1;
        if (stable_cnt == 8'd0) begin
          latched = 1'b0;
          trk_valid = 1'b0;
          trk_key = '0;
        end
      end
    end else begin
      if (hit && !trk_valid) begin
        trk_valid = 1'b1;
        trk_key = k;
        hold_cnt = '0;
        r.ev = EV_START;
        r.code = key_char(k);
      end else if (hit && trk_key == k) begin
        if (hold_cnt != 16'hFFFF) begin
          hold_cnt = hold_cnt + 16'd1;
          if (hold_cnt == long_q) begin
            r.ev = EV_LONG;
            r.code = key_char(trk_key);
          end
        end
      end else if (!hit && trk_valid) begin
        r.dur = hold_cnt;
        r.ev = (hold_cnt < long_q) ? EV_SHORT_REL : EV_LONG_REL;
        r.code = key_char(trk_key);
        trk_valid = 1'b0;
        trk_key = '0;
      end
    end
    pending_events.push_back(r);
  endfunction

  task automatic flag_mismatch(input string what);
    err_cnt++;
    $display("mismatch @%0d: %s", cycle_cnt, what);
  endtask

  // driver: offers queued snapshots, models each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_keys  <= '0;
    end else begin
      if (drv_valid && in_if.ready) track_scan(drv_keys);
      if (!drv_valid || in_if.ready) begin
        if (scan_q.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          drv_valid <= 1'b1;
          drv_keys  <= scan_q.pop_front();
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each event transaction and drives ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy <= 1'b0;
    end else begin
      if (out_if.valid && rdy) begin
        if (pending_events.size() == 0) begin
          flag_mismatch("event with nothing expected");
        end else begin
          want = pending_events.pop_front();
          if (out_if.event_res !== want.ev)
            flag_mismatch($sformatf("event_res %0d, want %0d", out_if.event_res, want.ev));
          if (out_if.key_code !== want.code)
            flag_mismatch($sformatf("key_code %h, want %h", out_if.key_code, want.code));
          if (out_if.hold_ticks !== want.dur)
            flag_mismatch($sformatf("hold_ticks %0d, want %0d", out_if.hold_ticks, want.dur));
        end
      end
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        stall_left = HOLD_OFF;
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy <= 1'b0;
      end else begin
        rdy <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_scan(input logic [KEYS_W-1:0] s, input int n);
    repeat (n) scan_q.push_back(s);
  endtask

  // checked between edges, once the driver's updates have settled
  task automatic wait_drained();
    while (!(scan_q.size() == 0 && !drv_valid && pending_events.size() == 0))
      @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // all three registers, written back to back while the unit is idle
  task automatic configure(input logic m, input logic [7:0] thr, input logic [15:0] lng);
    @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= CFG_MODE; cfg_data <= {15'd0, m};
    mode_q = m;
    @(posedge clk_i);
    cfg_idx <= CFG_STABLE; cfg_data <= {8'd0, thr};
    thr_q = thr;
    @(posedge clk_i);
    cfg_idx <= CFG_LONG; cfg_data <= lng;
    long_q = lng;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // mostly clean press/release sequences, some bounce and raw noise
  task automatic gen_traffic(input int n, input int hint);
    int made;
    int r;
    int k;
    int len;
    logic [KEYS_W-1:0] above;
    logic [KEYS_W-1:0] snap;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      k = $urandom_range(15);
      above = ~((16'h2 << k) - 16'h1);
      if (r < 70) begin
        len = $urandom_range(1, hint + 4);
        repeat (len) begin
          // extra closed keys after the first one do not change the pick
          snap = (16'h1 << k) | (16'($urandom) & above);
          scan_q.push_back(snap);
        end
        made += len;
        len = $urandom_range(1, hint + 4);
        push_scan('0, len);
        made += len;
      end else if (r < 85) begin
        len = $urandom_range(2, 8);
        for (int i = 0; i < len; i++) scan_q.push_back((i % 2 == 0) ? (16'h1 << k) : '0);
        made += len;
      end else begin
        scan_q.push_back(16'($urandom));
        made++;
      end
    end
  endtask

  initial begin
    int hint;
    logic m;
    logic [7:0] thr;
    logic [15:0] lng;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: debounced press, key change keeps latch, release
    push_scan(16'h0001, 3);
    push_scan(16'h0003, 1);
    push_scan(16'h0002, 3);
    push_scan(16'h0000, 3);
    push_scan(16'h8000, 3);
    push_scan(16'hFFFF, 1);
    push_scan(16'h0000, 1);
    wait_drained();

    // zero threshold acts as one
    configure(1'b0, 8'd0, 16'd100);
    push_scan(16'h0100, 2);
    push_scan(16'h0000, 2);
    wait_drained();

    // long press: start, long reached, change while held, releases
    configure(1'b1, 8'd3, 16'd2);
    push_scan(16'h0020, 3);
    push_scan(16'h0040, 1);
    push_scan(16'h0000, 1);
    push_scan(16'h0004, 1);
    push_scan(16'h0000, 1);
    wait_drained();

    // zero long-press ticks: every release is long
    configure(1'b1, 8'd3, 16'd0);
    push_scan(16'h1000, 2);
    push_scan(16'h0000, 1);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      no_idle = (p == 3);
      hold_off_req = (p == 5);
      m = 1'($urandom_range(1));
      thr = 8'($urandom_range(1, 6));
      lng = 16'($urandom_range(1, 12));
      if (p == 5) m = 1'b1;
      if (p == 7) begin
        m = 1'b0;
        thr = 8'd255;
      end
      if (p == 9) begin
        thr = 8'd1;
        lng = 16'd1;
      end
      configure(m, thr, lng);
      hint = m ? int'(lng) : int'(thr);
      gen_traffic((p == 5) ? 200 : ((p == 7) ? 200 : 60), hint);
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (8) @(posedge clk_i);
    if (pending_events.size() != 0) flag_mismatch("events never delivered");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
